>>> rtl/gha_pkg.sv
// Shared definitions for the generational handle allocator.
// Operation and status codes, default sizes and the result flag struct.
// No dependencies.
package gha_pkg;

  localparam int unsigned CapacityDef = 1024;
  localparam int unsigned GenWidthDef = 32;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned STAT_W      = 2;

  localparam logic [FUNC_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [FUNC_W-1:0] OP_DESTROY = 2'd1;
  localparam logic [FUNC_W-1:0] OP_CHECK   = 2'd2;
  localparam logic [FUNC_W-1:0] OP_LOOKUP  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_STALE = 2'd2;

  typedef struct packed {
    logic              handle_valid;
    logic [STAT_W-1:0] status;
  } gha_flags_t;

endpackage

>>> rtl/gha_core.sv
// Allocator core: request register, sequencer, generation table and free stack.
// Depends on gha_pkg; instantiated by generational_handle_allocator_top.
module gha_core import gha_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef,
  parameter int unsigned GEN_W    = GenWidthDef,
  localparam int unsigned IDX_W   = $clog2(CAPACITY)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [FUNC_W-1:0] req_func_i,
  input  logic [IDX_W-1:0]  req_index_i,
  input  logic [GEN_W-1:0]  req_gen_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [IDX_W-1:0]  res_index_o,
  output logic [GEN_W-1:0]  res_gen_o,
  output gha_flags_t        res_flags_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_GEN  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic              popped_q;
  logic [FUNC_W-1:0] func_q;
  logic [IDX_W-1:0]  idx_q;
  logic [GEN_W-1:0]  gen_q;
  logic [CNT_W-1:0]  free_count_q, free_count_d;
  logic [CNT_W-1:0]  next_fresh_q, next_fresh_d;

  logic [GEN_W-1:0]  gen_mem [CAPACITY];
  logic [IDX_W-1:0]  stk_mem [CAPACITY];
  logic [GEN_W-1:0]  gen_rdata_q;
  logic [IDX_W-1:0]  stk_rdata_q;

  logic              accept;
  logic              finish;
  logic [CNT_W-1:0]  count_dec;
  logic [IDX_W-1:0]  stk_raddr;
  logic [IDX_W-1:0]  gen_raddr;
  logic              gen_ren;
  logic              in_range;
  logic              current;

  logic              gen_we;
  logic [IDX_W-1:0]  gen_waddr;
  logic [GEN_W-1:0]  gen_wdata;
  logic              stk_we;
  logic              fresh;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign res_valid_o = (state_q == ST_GEN);
  assign finish      = res_valid_o && res_ready_i;

  assign count_dec = free_count_q - CNT_W'(1);
  assign stk_raddr = count_dec[IDX_W-1:0];
  assign gen_raddr = (state_q == ST_POP) ? stk_rdata_q : req_index_i;
  assign gen_ren   = accept || (state_q == ST_POP);

  assign in_range = CNT_W'(idx_q) < next_fresh_q;
  assign current  = in_range && (gen_rdata_q == gen_q);

  always_comb begin
    res_index_o              = idx_q;
    res_gen_o                = '0;
    res_flags_o.handle_valid = 1'b0;
    res_flags_o.status       = STAT_OK;
    gen_we                   = 1'b0;
    gen_waddr                = idx_q;
    gen_wdata                = gen_rdata_q + GEN_W'(1);
    stk_we                   = 1'b0;
    fresh                    = 1'b0;
    case (func_q)
      OP_CREATE: begin
        if (popped_q) begin
          res_gen_o = gen_rdata_q;
        end else if (next_fresh_q < CapCount) begin
          res_index_o = next_fresh_q[IDX_W-1:0];
          res_gen_o   = GEN_W'(1);
          gen_we      = 1'b1;
          gen_waddr   = next_fresh_q[IDX_W-1:0];
          gen_wdata   = GEN_W'(1);
          fresh       = 1'b1;
        end else begin
          res_index_o        = '0;
          res_flags_o.status = STAT_FULL;
        end
      end
      OP_DESTROY: begin
        if (current) begin
          res_flags_o.handle_valid = 1'b1;
          gen_we                   = 1'b1;
          stk_we                   = free_count_q < CapCount;
        end else begin
          res_flags_o.status = STAT_STALE;
        end
      end
      OP_CHECK: begin
        if (current) begin
          res_flags_o.handle_valid = 1'b1;
        end else begin
          res_flags_o.status = STAT_STALE;
        end
      end
      default: begin
        if (in_range) begin
          res_gen_o = gen_rdata_q;
        end else begin
          res_flags_o.status = STAT_STALE;
        end
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    free_count_d = free_count_q;
    next_fresh_d = next_fresh_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ((req_func_i == OP_CREATE) && (free_count_q != '0)) ? ST_POP : ST_GEN;
        end
      end
      ST_POP: begin
        state_d      = ST_GEN;
        free_count_d = count_dec;
      end
      ST_GEN: begin
        if (finish) begin
          state_d = ST_IDLE;
          if (stk_we) begin
            free_count_d = free_count_q + CNT_W'(1);
          end
          if (fresh) begin
            next_fresh_d = next_fresh_q + CNT_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      popped_q     <= 1'b0;
      free_count_q <= '0;
      next_fresh_q <= '0;
    end else begin
      state_q      <= state_d;
      free_count_q <= free_count_d;
      next_fresh_q <= next_fresh_d;
      if (accept) begin
        popped_q <= 1'b0;
      end else if (state_q == ST_POP) begin
        popped_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_func_i;
      idx_q  <= req_index_i;
      gen_q  <= req_gen_i;
    end else if (state_q == ST_POP) begin
      idx_q <= stk_rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
    if (finish && stk_we) begin
      stk_mem[free_count_q[IDX_W-1:0]] <= idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_ren) begin
      gen_rdata_q <= gen_mem[gen_raddr];
    end
    if (finish && gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_count_q <= CapCount) && (next_fresh_q <= CapCount))
    else $error("allocator counter beyond capacity");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |=> (free_count_q == $past(count_dec)) && popped_q)
    else $error("pop did not take one free entry");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && accept && req_func_i == OP_CREATE && free_count_q != '0)
      |=> (state_q == ST_POP))
    else $error("create with free entries skipped the pop");

  a_fresh_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && fresh) |-> (next_fresh_q < CapCount) && !popped_q)
    else $error("fresh index taken beyond capacity");

endmodule

>>> rtl/generational_handle_allocator_top.sv
// Generational handle allocator, top level.
// Unpacks the request stream, holds the result register; depends on gha_pkg, gha_core.
//
// Usage:
//   s_axis carries requests: func (create, destroy, check, lookup), an index and a
//   generation. m_axis returns exactly one result per request: index, generation,
//   handle_valid and status (ok, full, stale/out of range).
//   A request goes from acceptance to the result register through the generation
//   table read (destroy, check, lookup, fresh create) or through the free stack
//   read and then the generation table read (create from the free stack): the two
//   are dependent registered memory reads. The next request is accepted in the
//   cycle after the result is loaded, so each request is finished before the next is taken.
//   The result register frees the core as soon as the result is loaded; a stalled
//   receiver holds m_axis steady and blocks only the completion of the next
//   request.
//   Reset clears the free count and the fresh index counter; no memory sweep
//   is needed, requests are taken from the first cycle after reset.
module generational_handle_allocator_top import gha_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef,
  parameter int unsigned GEN_W    = GenWidthDef,
  localparam int unsigned IDX_W   = $clog2(CAPACITY),
  localparam int unsigned IN_W    = FUNC_W + IDX_W + GEN_W,
  localparam int unsigned IN_TW   = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W   = IDX_W + GEN_W + 1 + STAT_W,
  localparam int unsigned OUT_TW  = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_TW-1:0]  s_axis_tdata,   // func, entity_index, entity_generation
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_TW-1:0] m_axis_tdata    // out_index, out_generation, handle_valid, status
);

  logic              res_valid;
  logic              res_ready;
  logic [IDX_W-1:0]  res_index;
  logic [GEN_W-1:0]  res_gen;
  gha_flags_t        res_flags;

  logic              m_tvalid_q, m_tvalid_d;
  logic [IDX_W-1:0]  out_index_q;
  logic [GEN_W-1:0]  out_gen_q;
  gha_flags_t        out_flags_q;

  gha_core #(
    .CAPACITY (CAPACITY),
    .GEN_W    (GEN_W)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_func_i  (s_axis_tdata[FUNC_W-1:0]),
    .req_index_i (s_axis_tdata[FUNC_W+IDX_W-1:FUNC_W]),
    .req_gen_i   (s_axis_tdata[IN_W-1:FUNC_W+IDX_W]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_index_o (res_index),
    .res_gen_o   (res_gen),
    .res_flags_o (res_flags)
  );

  assign res_ready = !m_tvalid_q || m_axis_tready;

  always_comb begin
    m_tvalid_d = m_tvalid_q;
    if (res_ready) begin
      m_tvalid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else begin
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_index_q <= res_index;
      out_gen_q   <= res_gen;
      out_flags_q <= res_flags;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = OUT_TW'({out_flags_q.status, out_flags_q.handle_valid,
                                  out_gen_q, out_index_q});

endmodule
